FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the job deadline table.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");

`endif

FILE: src/jdt_pkg.sv
// Package of the job deadline table: codes, defaults and the cell control struct.
// Depends on nothing; imported by jdt_cell and job_deadline_timeout_table.
package jdt_pkg;

  localparam int MAX_JOBS_DEF  = 64;
  localparam int TIME_BITS_DEF = 48;
  localparam int CMD_BITS      = 2;
  localparam int ID_BITS       = 6;
  localparam int TIMEOUT_BITS  = 32;
  localparam int KIND_BITS     = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_NO_EXPIRY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic               sched;
    logic               cancel;
    logic               tick;
    logic               shift;
    logic [ID_BITS-1:0] job_id;
  } cell_ctl_t;

endpackage

FILE: src/jdt_cell.sv
// One slot of the job deadline table: valid bit, deadline and a hit flag
// that shifts toward the head of the chain. Depends on jdt_pkg.
module jdt_cell #(
  parameter int CELL_ID   = 0,
  parameter int TIME_BITS = jdt_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  jdt_pkg::cell_ctl_t    ctl,
  input  logic [TIME_BITS-1:0]  deadline_in,
  input  logic [TIME_BITS-1:0]  now_next,
  input  logic                  hit_in,
  output logic                  hit_out
);
  import jdt_pkg::*;

  logic                 valid;
  logic                 hit;
  logic [TIME_BITS-1:0] deadline;
  logic                 sel;
  logic                 match;

  assign sel     = (ctl.job_id == ID_BITS'(CELL_ID));
  assign match   = valid && (deadline == now_next);
  assign hit_out = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.tick) begin
        // latch expiry and drop the slot
        hit <= match;
        if (match) begin
          valid <= 1'b0;
        end
      end else if (ctl.shift) begin
        hit <= hit_in;
      end
      if (sel && ctl.sched) begin
        valid <= 1'b1;
      end
      if (sel && ctl.cancel) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && ctl.sched) begin
      deadline <= deadline_in;
    end
  end

endmodule

FILE: src/job_deadline_timeout_table.sv
// Schedule/cancel: result in the cycle after the request; next request the cycle after.
// Tick: busy while expiry flags walk the cell chain one cell per cycle; expired jobs
//   report in ascending id order, or one no-expiry result when nothing expires.
//   Results cannot be stalled by the receiver.
// Synchronous active-high reset: time zero, all slots empty, no result pending.
// Depends on jdt_pkg, jdt_cell and assert_macros.svh.
`include "assert_macros.svh"

module job_deadline_timeout_table #(
  parameter int MAX_JOBS  = jdt_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = jdt_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // request port
  input  logic                               start,
  output logic                               busy,
  input  logic [jdt_pkg::CMD_BITS-1:0]       command,
  input  logic [jdt_pkg::ID_BITS-1:0]        job_id,
  input  logic [jdt_pkg::TIMEOUT_BITS-1:0]   timeout,
  // result port, one cycle per result
  output logic                               strobe,
  output logic [jdt_pkg::KIND_BITS-1:0]      kind,
  output logic [jdt_pkg::ID_BITS-1:0]        expired_job,
  output logic                               last
);
  import jdt_pkg::*;

  // Job ids are 6 bits wide, so only the first 64 slots can ever be addressed.
  localparam int NUM_CELLS = (MAX_JOBS < 64) ? MAX_JOBS : 64;
  localparam int IDX_BITS  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  state_t               state;
  logic [TIME_BITS-1:0] time_now;
  logic [TIME_BITS-1:0] now_next;
  logic [TIME_BITS-1:0] deadline_in;
  logic [IDX_BITS-1:0]  scan_idx;
  logic [NUM_CELLS-1:0] hits;
  logic [NUM_CELLS:0]   hit_chain;
  logic                 accept;
  logic                 sched_ok;
  logic                 rest_empty;
  cell_ctl_t            ctl;

  assign busy        = (state == ST_SCAN);
  assign accept      = start && !busy;
  assign now_next    = time_now + TIME_BITS'(1);
  assign deadline_in = time_now + TIME_BITS'(timeout);
  assign sched_ok    = (timeout != '0) && (32'(job_id) < 32'(MAX_JOBS));
  assign rest_empty  = (hits[NUM_CELLS-1:1] == '0);

  // Broadcast control; a schedule with a zero timeout or an out-of-range job never writes a slot.
  always_comb begin
    ctl.sched  = accept && (command == CMD_SCHEDULE) && sched_ok;
    ctl.cancel = accept && (command == CMD_CANCEL);
    ctl.tick   = accept && (command == CMD_TICK);
    ctl.shift  = (state == ST_SCAN);
    ctl.job_id = job_id;
  end

  // Chain of slots: each hit flag moves one cell toward slot 0 per scan cycle,
  // so the head sees expired jobs in ascending id order.
  assign hit_chain[NUM_CELLS] = 1'b0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    jdt_cell #(
      .CELL_ID   (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .deadline_in (deadline_in),
      .now_next    (now_next),
      .hit_in      (hit_chain[i+1]),
      .hit_out     (hit_chain[i])
    );
    assign hits[i] = hit_chain[i];
  end

  // Sequencer and registered result port.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      time_now <= '0;
      strobe   <= 1'b0;
      scan_idx <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_t'(command))
              CMD_SCHEDULE: begin
                strobe <= 1'b1;
              end
              CMD_CANCEL: begin
                strobe <= 1'b1;
              end
              CMD_TICK: begin
                // advance time; cells compare against the new time this edge
                time_now <= now_next;
                scan_idx <= '0;
                state    <= ST_SCAN;
              end
              default: begin
                // unused code: drop the request
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + IDX_BITS'(1);
          if (hits == '0) begin
            // nothing expired on this tick
            strobe <= 1'b1;
            state  <= ST_IDLE;
          end else if (hits[0]) begin
            strobe <= 1'b1;
            if (rest_empty) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload of the result port; qualified by strobe, so no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (hits == '0) begin
        kind        <= KIND_NO_EXPIRY;
        expired_job <= '0;
        last        <= 1'b1;
      end else begin
        kind        <= KIND_EXPIRED;
        expired_job <= ID_BITS'(scan_idx);
        last        <= rest_empty;
      end
    end else begin
      kind        <= (command == CMD_CANCEL) ? KIND_CANCELLED :
                     (sched_ok ? KIND_SCHEDULED : KIND_REJECTED);
      expired_job <= job_id;
      last        <= 1'b1;
    end
  end

  // A tick request always enters the scan.
  `ASSERT_NEXT(a_tick_scans, clk, rst, accept && (command == CMD_TICK), busy)
  // Schedule and cancel answer with one final result in the next cycle.
  `ASSERT_NEXT(a_ack_next, clk, rst,
    accept && ((command == CMD_SCHEDULE) || (command == CMD_CANCEL)), strobe && last)
  // Expiry results come only from the scan.
  `ASSERT_IMPLIES(a_exp_from_scan, clk, rst, strobe && (kind == KIND_EXPIRED),
    $past(state) == ST_SCAN)
  // The scan never leaves expiry flags behind.
  `ASSERT_IMPLIES(a_idle_no_hits, clk, rst, state == ST_IDLE, hits == '0)

endmodule
